FILE: rtl/msb_pkg.sv
// shared constants, codes and types of the meshlet scan builder
// depends on nothing; imported by msb_ctrl and meshlet_scan_builder
package msb_pkg;

  localparam int VERTEX_SLOTS          = 65536;
  localparam int MAX_MESHLET_VERTICES  = 255;
  localparam int MAX_MESHLET_TRIANGLES = 512;
  localparam int LIST_DEPTH            = 255;

  localparam int MAP_AW  = $clog2(VERTEX_SLOTS);
  localparam int LIST_AW = $clog2(LIST_DEPTH);

  localparam logic [7:0] EMPTY_SLOT = 8'hff;

  // configuration register indexes
  localparam logic CFG_VERTEX_LIMIT   = 1'b0;
  localparam logic CFG_TRIANGLE_LIMIT = 1'b1;

  // input modes
  localparam logic MODE_TRIANGLE = 1'b0;
  localparam logic MODE_END      = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_DESC   = 2'd0;
  localparam logic [1:0] KIND_VERTEX = 2'd1;
  localparam logic [1:0] KIND_TRI    = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] first_vertex_slot;
    logic [31:0] first_triangle_byte;
    logic [7:0]  vertices_in_meshlet;
    logic [9:0]  triangles_in_meshlet;
    logic [15:0] global_vertex;
    logic [7:0]  local_first;
    logic [7:0]  local_second;
    logic [7:0]  local_third;
    logic        last;
  } result_t;

  typedef struct packed {
    logic              map_we;
    logic [MAP_AW-1:0] map_waddr;
    logic [7:0]        map_wdata;
    logic [MAP_AW-1:0] map_raddr;
    logic              list_we;
    logic [LIST_AW-1:0] list_waddr;
    logic [15:0]       list_wdata;
    logic [LIST_AW-1:0] list_raddr;
  } mem_req_t;

  function automatic logic [MAP_AW-1:0] map_index(input logic [15:0] v);
    return MAP_AW'(v);
  endfunction

  // triangle bytes of a meshlet, three per triangle, rounded up to four
  function automatic logic [11:0] pad_bytes(input logic [9:0] tris);
    logic [11:0] raw;
    raw = {2'b00, tris} + {1'b0, tris, 1'b0} + 12'd3;
    return raw & ~12'd3;
  endfunction

endpackage

FILE: rtl/msb_ram.sv
// generic simple dual-port synchronous ram, one write and one registered read
// depends on nothing
module msb_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/msb_ctrl.sv
// sequencer: slot map clearing sweep, corner lookups, meshlet close walk and
// corner placement; drives both rams and the result stage; uses msb_pkg
module msb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_mode,
  input  logic [15:0]         in_vertex_a,
  input  logic [15:0]         in_vertex_b,
  input  logic [15:0]         in_vertex_c,
  input  logic [7:0]          vlim,
  input  logic [9:0]          tlim,
  input  logic                out_free,
  output logic                res_push,
  output msb_pkg::result_t    res,
  output msb_pkg::mem_req_t   mem_req,
  input  logic [7:0]          map_rdata,
  input  logic [15:0]         list_rdata
);
  import msb_pkg::*;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RDB   = 4'd2;
  localparam logic [3:0] S_RDC   = 4'd3;
  localparam logic [3:0] S_DEC   = 4'd4;
  localparam logic [3:0] S_CDESC = 4'd5;
  localparam logic [3:0] S_WALK  = 4'd6;
  localparam logic [3:0] S_PA    = 4'd7;
  localparam logic [3:0] S_PB    = 4'd8;
  localparam logic [3:0] S_PC    = 4'd9;
  localparam logic [3:0] S_TRI   = 4'd10;

  logic [3:0]        state_r, state_nxt;
  logic [MAP_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic              end_r, end_nxt;
  logic [15:0]       va_r, va_nxt, vb_r, vb_nxt, vc_r, vc_nxt;
  logic [7:0]        sa_r, sa_nxt, sb_r, sb_nxt, sc_r, sc_nxt;
  logic [7:0]        la_r, la_nxt, lb_r, lb_nxt, lc_r, lc_nxt;
  logic [7:0]        vcnt_r, vcnt_nxt;
  logic [9:0]        tcnt_r, tcnt_nxt;
  logic [31:0]       vbase_r, vbase_nxt, tbase_r, tbase_nxt;
  logic [7:0]        walk_j_r, walk_j_nxt;
  logic              walk_pend_r, walk_pend_nxt;

  logic              accept;
  logic [1:0]        extra;
  logic              do_close;
  logic [15:0]       cur_v;
  logic [7:0]        cur_eff;
  logic              new_v;
  logic [7:0]        cur_slot;
  logic              walk_issue;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // corner lookups in the decision cycle: c arrives straight from the ram
  always_comb begin
    extra = {1'b0, sa_r == EMPTY_SLOT} + {1'b0, sb_r == EMPTY_SLOT}
          + {1'b0, map_rdata == EMPTY_SLOT};
    do_close = (tcnt_r != 10'd0) &&
               (({1'b0, vcnt_r} + {7'd0, extra} > {1'b0, vlim}) || (tcnt_r >= tlim));
  end

  // slot of the corner being placed, forwarded from earlier corners of the item
  always_comb begin
    cur_v   = va_r;
    cur_eff = sa_r;
    case (state_r)
      S_PB: begin
        cur_v   = vb_r;
        cur_eff = (map_index(vb_r) == map_index(va_r)) ? la_r : sb_r;
      end
      S_PC: begin
        cur_v = vc_r;
        if (map_index(vc_r) == map_index(vb_r)) begin
          cur_eff = lb_r;
        end else if (map_index(vc_r) == map_index(va_r)) begin
          cur_eff = la_r;
        end else begin
          cur_eff = sc_r;
        end
      end
      default: begin
        cur_v   = va_r;
        cur_eff = sa_r;
      end
    endcase
    new_v    = (cur_eff == EMPTY_SLOT) && ({24'd0, vcnt_r} < LIST_DEPTH);
    cur_slot = new_v ? vcnt_r : cur_eff;
  end

  assign walk_issue = (walk_j_r < vcnt_r);

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    end_nxt       = end_r;
    va_nxt        = va_r;
    vb_nxt        = vb_r;
    vc_nxt        = vc_r;
    sa_nxt        = sa_r;
    sb_nxt        = sb_r;
    sc_nxt        = sc_r;
    la_nxt        = la_r;
    lb_nxt        = lb_r;
    lc_nxt        = lc_r;
    vcnt_nxt      = vcnt_r;
    tcnt_nxt      = tcnt_r;
    vbase_nxt     = vbase_r;
    tbase_nxt     = tbase_r;
    walk_j_nxt    = walk_j_r;
    walk_pend_nxt = walk_pend_r;

    res_push = 1'b0;
    res      = '0;

    mem_req            = '0;
    mem_req.map_raddr  = map_index(va_r);
    mem_req.list_raddr = LIST_AW'(walk_j_r);

    unique case (state_r)
      S_CLR: begin
        mem_req.map_we    = 1'b1;
        mem_req.map_waddr = clr_cnt_r;
        mem_req.map_wdata = EMPTY_SLOT;
        clr_cnt_nxt       = clr_cnt_r + 1'b1;
        if (clr_cnt_r == {MAP_AW{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        mem_req.map_raddr = map_index(in_vertex_a);
        if (accept) begin
          va_nxt  = in_vertex_a;
          vb_nxt  = in_vertex_b;
          vc_nxt  = in_vertex_c;
          end_nxt = (in_mode == MODE_END);
          if (in_mode == MODE_END) begin
            if (tcnt_r != 10'd0) begin
              state_nxt = S_CDESC;
            end
          end else begin
            state_nxt = S_RDB;
          end
        end
      end
      S_RDB: begin
        mem_req.map_raddr = map_index(vb_r);
        sa_nxt            = map_rdata;
        state_nxt         = S_RDC;
      end
      S_RDC: begin
        mem_req.map_raddr = map_index(vc_r);
        sb_nxt            = map_rdata;
        state_nxt         = S_DEC;
      end
      S_DEC: begin
        sc_nxt    = map_rdata;
        state_nxt = do_close ? S_CDESC : S_PA;
      end
      S_CDESC: begin
        if (out_free) begin
          res_push                 = 1'b1;
          res.kind                 = KIND_DESC;
          res.first_vertex_slot    = vbase_r;
          res.first_triangle_byte  = tbase_r;
          res.vertices_in_meshlet  = vcnt_r;
          res.triangles_in_meshlet = tcnt_r;
          res.last                 = end_r;
          walk_j_nxt               = 8'd0;
          walk_pend_nxt            = 1'b0;
          state_nxt                = S_WALK;
        end
      end
      S_WALK: begin
        // read list entry j, clear its mark in the next cycle
        if (walk_pend_r) begin
          mem_req.map_we    = 1'b1;
          mem_req.map_waddr = map_index(list_rdata);
          mem_req.map_wdata = EMPTY_SLOT;
        end
        walk_pend_nxt = walk_issue;
        if (walk_issue) begin
          walk_j_nxt = walk_j_r + 8'd1;
        end
        if (!walk_issue && !walk_pend_r) begin
          vbase_nxt = vbase_r + {24'd0, vcnt_r};
          tbase_nxt = tbase_r + {20'd0, pad_bytes(tcnt_r)};
          vcnt_nxt  = 8'd0;
          tcnt_nxt  = 10'd0;
          // every mark is clear once the open meshlet is gone
          sa_nxt    = EMPTY_SLOT;
          sb_nxt    = EMPTY_SLOT;
          sc_nxt    = EMPTY_SLOT;
          state_nxt = end_r ? S_IDLE : S_PA;
        end
      end
      S_PA, S_PB, S_PC: begin
        if (!new_v || out_free) begin
          if (new_v) begin
            res_push           = 1'b1;
            res.kind           = KIND_VERTEX;
            res.global_vertex  = cur_v;
            mem_req.map_we     = 1'b1;
            mem_req.map_waddr  = map_index(cur_v);
            mem_req.map_wdata  = vcnt_r;
            mem_req.list_we    = 1'b1;
            mem_req.list_waddr = LIST_AW'(vcnt_r);
            mem_req.list_wdata = cur_v;
            vcnt_nxt           = vcnt_r + 8'd1;
          end
          if (state_r == S_PA) begin
            la_nxt    = cur_slot;
            state_nxt = S_PB;
          end else if (state_r == S_PB) begin
            lb_nxt    = cur_slot;
            state_nxt = S_PC;
          end else begin
            lc_nxt    = cur_slot;
            state_nxt = S_TRI;
          end
        end
      end
      S_TRI: begin
        if (out_free) begin
          res_push         = 1'b1;
          res.kind         = KIND_TRI;
          res.local_first  = la_r;
          res.local_second = lb_r;
          res.local_third  = lc_r;
          res.last         = 1'b1;
          if (tcnt_r != 10'h3ff) begin
            tcnt_nxt = tcnt_r + 10'd1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      end_r       <= 1'b0;
      vcnt_r      <= 8'd0;
      tcnt_r      <= 10'd0;
      vbase_r     <= 32'd0;
      tbase_r     <= 32'd0;
      walk_j_r    <= 8'd0;
      walk_pend_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      end_r       <= end_nxt;
      vcnt_r      <= vcnt_nxt;
      tcnt_r      <= tcnt_nxt;
      vbase_r     <= vbase_nxt;
      tbase_r     <= tbase_nxt;
      walk_j_r    <= walk_j_nxt;
      walk_pend_r <= walk_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    va_r <= va_nxt;
    vb_r <= vb_nxt;
    vc_r <= vc_nxt;
    sa_r <= sa_nxt;
    sb_r <= sb_nxt;
    sc_r <= sc_nxt;
    la_r <= la_nxt;
    lb_r <= lb_nxt;
    lc_r <= lc_nxt;
  end

endmodule

FILE: rtl/meshlet_scan_builder.sv
// meshlet scan builder: a triangle holds the input through the accepting cycle, three
// slot map reads, three corner placements and the triangle result, however many of its
// corners are new; a new corner and the triangle result wait while the output is not free
// a meshlet close adds the descriptor, then the mark-clearing walk over every vertex of the
// closed meshlet in the list ram; an end item on an open meshlet takes the same descriptor
// and walk; one item at a time, and a result waiting on out_stall holds the item longer
// after reset the slot map is swept to empty, all 65536 slots, with in_stall high;
// configuration writes are taken throughout
module meshlet_scan_builder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [9:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [15:0] in_vertex_a,
  input  logic [15:0] in_vertex_b,
  input  logic [15:0] in_vertex_c,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [31:0] out_first_vertex_slot,
  output logic [31:0] out_first_triangle_byte,
  output logic [7:0]  out_vertices_in_meshlet,
  output logic [9:0]  out_triangles_in_meshlet,
  output logic [15:0] out_global_vertex,
  output logic [7:0]  out_local_first,
  output logic [7:0]  out_local_second,
  output logic [7:0]  out_local_third,
  output logic        out_last
);
  import msb_pkg::*;

  logic [7:0] vertex_limit_r;
  logic [9:0] triangle_limit_r;
  logic [7:0] vlim;
  logic [9:0] tlim;

  logic       out_valid_r;
  result_t    out_r;
  logic       out_free;
  logic       res_push;
  result_t    res;
  mem_req_t   mem_req;
  logic [7:0]  map_rdata;
  logic [15:0] list_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_limit_r   <= 8'd64;
      triangle_limit_r <= 10'd124;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VERTEX_LIMIT:   vertex_limit_r   <= cfg_wdata[7:0];
        CFG_TRIANGLE_LIMIT: triangle_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // limits capped at MAX_MESHLET_VERTICES (what the rams can hold) and MAX_MESHLET_TRIANGLES
  assign vlim = ({24'd0, vertex_limit_r} < MAX_MESHLET_VERTICES) ? vertex_limit_r
              : 8'(MAX_MESHLET_VERTICES);
  assign tlim = ({22'd0, triangle_limit_r} < MAX_MESHLET_TRIANGLES) ? triangle_limit_r
              : 10'(MAX_MESHLET_TRIANGLES);

  msb_ram #(
    .DEPTH (VERTEX_SLOTS),
    .WIDTH (8)
  ) u_slot_map (
    .clk   (clk),
    .we    (mem_req.map_we),
    .waddr (mem_req.map_waddr),
    .wdata (mem_req.map_wdata),
    .raddr (mem_req.map_raddr),
    .rdata (map_rdata)
  );

  msb_ram #(
    .DEPTH (LIST_DEPTH),
    .WIDTH (16)
  ) u_vertex_list (
    .clk   (clk),
    .we    (mem_req.list_we),
    .waddr (mem_req.list_waddr),
    .wdata (mem_req.list_wdata),
    .raddr (mem_req.list_raddr),
    .rdata (list_rdata)
  );

  msb_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_mode     (in_mode),
    .in_vertex_a (in_vertex_a),
    .in_vertex_b (in_vertex_b),
    .in_vertex_c (in_vertex_c),
    .vlim        (vlim),
    .tlim        (tlim),
    .out_free    (out_free),
    .res_push    (res_push),
    .res         (res),
    .mem_req     (mem_req),
    .map_rdata   (map_rdata),
    .list_rdata  (list_rdata)
  );

  // output register: free when empty or being taken this cycle
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      out_r <= res;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_kind                 = out_r.kind;
  assign out_first_vertex_slot    = out_r.first_vertex_slot;
  assign out_first_triangle_byte  = out_r.first_triangle_byte;
  assign out_vertices_in_meshlet  = out_r.vertices_in_meshlet;
  assign out_triangles_in_meshlet = out_r.triangles_in_meshlet;
  assign out_global_vertex        = out_r.global_vertex;
  assign out_local_first          = out_r.local_first;
  assign out_local_second         = out_r.local_second;
  assign out_local_third          = out_r.local_third;
  assign out_last                 = out_r.last;

endmodule
